@@ rtl/pmc_pkg.sv @@
// shared types, codes and constants of the pointer motion conditioner
`timescale 1ns / 1ps
package pmc_pkg;

    // input beat: one mouse poll
    typedef struct packed {
        logic signed [15:0] raw_dx;
        logic signed [15:0] raw_dy;
        logic signed [15:0] raw_wheel;
        logic [7:0]         buttons_down;
        logic [15:0]        frame_time;
        logic               in_menu;
    } t_in;

    // output beat: one conditioned result
    typedef struct packed {
        logic signed [23:0] move_x;
        logic signed [23:0] move_y;
        logic signed [15:0] wheel_delta;
        logic [9:0]         pressed_mask;
        logic [9:0]         released_mask;
        logic [17:0]        cursor_x;
        logic [17:0]        cursor_y;
    } t_out;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_CAP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTER_GAIN  = 3'd5;

    // arithmetic constants
    localparam logic [12:0] DT_MAX        = 13'd6554;
    localparam logic [7:0]  BLEND_K_MAX   = 8'd230;
    localparam logic [11:0] BLEND_LEN_MAX = 12'd2560;
    localparam logic [20:0] RECIP_TEN     = 21'd1677722;   // ceil(2^24 / 10)
    localparam logic [15:0] SF_AVERAGE    = 16'd256;

    // smoothing mode
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_BLEND = 2'd1,
        MODE_AVG   = 2'd2,
        MODE_RATE  = 2'd3
    } t_mode;

    // datapath operations, one per sequencer step
    typedef enum logic [4:0] {
        OP_IDLE, OP_A0, OP_A1, OP_A2, OP_A3, OP_A4, OP_AVG,
        OP_B0, OP_B1, OP_B2, OP_SQ, OP_B4, OP_B5, OP_B6,
        OP_R0, OP_R1, OP_S0, OP_S1, OP_S2, OP_M0, OP_C1, OP_C2, OP_FIN
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  sqrt_last;
        logic  out_free;
    } t_sts;

    // magnitude helpers
    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-e) : e;
    endfunction

    function automatic logic [23:0] abs24(input logic signed [23:0] v);
        return v[23] ? 24'(-v) : 24'(v);
    endfunction

    function automatic logic [24:0] abs25(input logic signed [24:0] v);
        return v[24] ? 25'(-v) : 25'(v);
    endfunction

endpackage

@@ rtl/pmc_ctrl.sv @@
// sequencer of the pointer motion conditioner
`timescale 1ns / 1ps
module pmc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pmc_pkg::t_sts i_sts,
    output pmc_pkg::t_cmd o_cmd
);
    import pmc_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE = 23'h000001, S_A0 = 23'h000002, S_A1 = 23'h000004,
        S_A2   = 23'h000008, S_A3 = 23'h000010, S_A4 = 23'h000020,
        S_AVG  = 23'h000040, S_B0 = 23'h000080, S_B1 = 23'h000100,
        S_B2   = 23'h000200, S_SQ = 23'h000400, S_B4 = 23'h000800,
        S_B5   = 23'h001000, S_B6 = 23'h002000, S_R0 = 23'h004000,
        S_R1   = 23'h008000, S_S0 = 23'h010000, S_S1 = 23'h020000,
        S_S2   = 23'h040000, S_M0 = 23'h080000, S_C1 = 23'h100000,
        S_C2   = 23'h200000, S_FIN = 23'h400000
    } t_state;

    t_state r_state, n_state;
    logic   w_take;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_take     = i_in_valid && (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_take) n_state = S_A0;
            S_A0:   n_state = S_A1;
            S_A1:   n_state = S_A2;
            S_A2:   n_state = S_A3;
            S_A3:   n_state = S_A4;
            S_A4: begin
                case (i_sts.mode)
                    MODE_BLEND: n_state = S_B0;
                    MODE_AVG:   n_state = S_AVG;
                    MODE_RATE:  n_state = S_R0;
                    default:    n_state = S_M0;
                endcase
            end
            S_AVG:  n_state = S_M0;
            S_B0:   n_state = S_B1;
            S_B1:   n_state = S_B2;
            S_B2:   n_state = S_SQ;
            S_SQ:   if (i_sts.sqrt_last) n_state = S_B4;
            S_B4:   n_state = S_B5;
            S_B5:   n_state = S_B6;
            S_B6:   n_state = S_S0;
            S_R0:   n_state = S_R1;
            S_R1:   n_state = S_S0;
            S_S0:   n_state = S_S1;
            S_S1:   n_state = S_S2;
            S_S2:   n_state = S_M0;
            S_M0:   n_state = S_C1;
            S_C1:   n_state = S_C2;
            S_C2:   n_state = S_FIN;
            S_FIN:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command decode
    always_comb begin
        o_cmd.load = w_take;
        case (r_state)
            S_A0:   o_cmd.op = OP_A0;
            S_A1:   o_cmd.op = OP_A1;
            S_A2:   o_cmd.op = OP_A2;
            S_A3:   o_cmd.op = OP_A3;
            S_A4:   o_cmd.op = OP_A4;
            S_AVG:  o_cmd.op = OP_AVG;
            S_B0:   o_cmd.op = OP_B0;
            S_B1:   o_cmd.op = OP_B1;
            S_B2:   o_cmd.op = OP_B2;
            S_SQ:   o_cmd.op = OP_SQ;
            S_B4:   o_cmd.op = OP_B4;
            S_B5:   o_cmd.op = OP_B5;
            S_B6:   o_cmd.op = OP_B6;
            S_R0:   o_cmd.op = OP_R0;
            S_R1:   o_cmd.op = OP_R1;
            S_S0:   o_cmd.op = OP_S0;
            S_S1:   o_cmd.op = OP_S1;
            S_S2:   o_cmd.op = OP_S2;
            S_M0:   o_cmd.op = OP_M0;
            S_C1:   o_cmd.op = OP_C1;
            S_C2:   o_cmd.op = OP_C2;
            S_FIN:  o_cmd.op = OP_FIN;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    // checks
    a_fin_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && i_sts.out_free |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after result");
    a_sqrt_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) && i_sts.sqrt_last |=> (r_state == S_B4))
        else $error("root iteration did not end on last step");
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_state == S_A0))
        else $error("accepted beat did not start the sequence");

endmodule

@@ rtl/pmc_dp.sv @@
// datapath: shared multiplier, root unit, state and result register
`timescale 1ns / 1ps
module pmc_dp #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600,
    parameter int BUTTON_COUNT  = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pmc_pkg::t_cmd                      i_cmd,
    output pmc_pkg::t_sts                      o_sts,
    input  pmc_pkg::t_in                       i_in_data,
    input  logic                               i_cfg_we,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pmc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pmc_pkg::t_out                      o_out_data
);
    import pmc_pkg::*;

    localparam logic [17:0] X_RST = 18'((SCREEN_WIDTH / 2) * 256);
    localparam logic [17:0] Y_RST = 18'((SCREEN_HEIGHT / 2) * 256);
    localparam logic [17:0] X_MAX = 18'((SCREEN_WIDTH - 1) * 256);
    localparam logic [17:0] Y_MAX = 18'((SCREEN_HEIGHT - 1) * 256);
    localparam logic [7:0]  BTN_MASK = 8'((1 << BUTTON_COUNT) - 1);

    // configuration
    logic [15:0] r_gain, r_sf, r_decel, r_pgain;
    logic [22:0] r_cap;
    logic        r_mirror;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= '0;
            r_cap    <= 23'd25600;
            r_sf     <= '0;
            r_decel  <= '0;
            r_mirror <= 1'b0;
            r_pgain  <= 16'd819;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACCEL_GAIN:    r_gain   <= i_cfg_wdata[15:0];
                CFG_ACCEL_CAP:     r_cap    <= i_cfg_wdata;
                CFG_SMOOTH_FACTOR: r_sf     <= i_cfg_wdata[15:0];
                CFG_DECEL_RATE:    r_decel  <= i_cfg_wdata[15:0];
                CFG_MIRROR_ENABLE: r_mirror <= i_cfg_wdata[0];
                CFG_POINTER_GAIN:  r_pgain  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // working registers
    t_in                r_in;
    logic signed [23:0] r_cx, r_cy, r_ox, r_oy;
    logic [55:0]        r_prod;
    logic [49:0]        r_acc, r_rem, r_root, r_bit;
    logic [16:0]        r_frac;
    logic [17:0]        r_pos_x, r_pos_y;
    logic [9:0]         r_prev_act;
    logic               r_out_valid;
    t_out               r_out;

    // mode select
    t_mode w_mode;
    always_comb begin
        if (r_sf == '0)               w_mode = MODE_NONE;
        else if (r_sf < SF_AVERAGE)   w_mode = MODE_BLEND;
        else if (r_sf == SF_AVERAGE)  w_mode = MODE_AVG;
        else                          w_mode = MODE_RATE;
    end
    assign o_sts.mode      = w_mode;
    assign o_sts.sqrt_last = r_bit[0];
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // differences to previous smoothed value
    logic signed [24:0] w_lx, w_ly;
    logic [24:0]        w_mlx, w_mly;
    assign w_lx  = 25'({r_cx[23], r_cx} - {r_ox[23], r_ox});
    assign w_ly  = 25'({r_cy[23], r_cy} - {r_oy[23], r_oy});
    assign w_mlx = abs25(w_lx);
    assign w_mly = abs25(w_ly);

    // accelerated delta from product
    logic [38:0]        w_accm;
    logic [22:0]        w_accs;
    logic               w_dneg;
    logic signed [15:0] w_d;
    logic signed [23:0] w_acc;
    assign w_d    = (i_cmd.op == OP_A2) ? r_in.raw_dx : r_in.raw_dy;
    assign w_dneg = w_d[15];
    assign w_accm = r_prod[46:8];
    assign w_accs = (w_accm > {16'd0, r_cap}) ? r_cap : w_accm[22:0];
    always_comb begin
        if (r_gain == '0) w_acc = {w_d, 8'd0};
        else if (w_dneg)  w_acc = 24'(-{1'b0, w_accs});
        else              w_acc = {1'b0, w_accs};
    end

    // stop test and rate operand
    logic [23:0] w_mcx, w_mcy;
    logic        w_stop;
    logic [16:0] w_rate;
    logic [12:0] w_dt;
    assign w_mcx  = abs24(r_cx);
    assign w_mcy  = abs24(r_cy);
    assign w_stop = (w_mcx <= 24'd2) && (w_mcy <= 24'd2) &&
                    !((w_mcx == 24'd2) && (w_mcy == 24'd2));
    always_comb begin
        if (!w_stop)               w_rate = {1'b0, r_sf};
        else if (r_decel != '0)    w_rate = {1'b0, r_decel};
        else                       w_rate = {r_sf, 1'b0};
    end
    assign w_dt = (r_in.frame_time < {3'd0, DT_MAX}) ? r_in.frame_time[12:0] : DT_MAX;

    // blend length and weight
    logic [11:0] w_lenc;
    logic [7:0]  w_k;
    assign w_lenc = (r_root > {38'd0, BLEND_LEN_MAX}) ? BLEND_LEN_MAX : r_root[11:0];
    assign w_k    = (r_sf[7:0] < BLEND_K_MAX) ? r_sf[7:0] : BLEND_K_MAX;

    // shared multiplier operands
    logic [30:0] w_ma;
    logic [24:0] w_mb;
    logic        w_mul;
    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_mul = 1'b1;
        case (i_cmd.op)
            OP_A0: begin w_ma = 31'(abs16(r_in.raw_dx)); w_mb = 25'(abs16(r_in.raw_dx)); end
            OP_A1, OP_A3: begin w_ma = r_prod[30:0]; w_mb = {9'd0, r_gain}; end
            OP_A2: begin w_ma = 31'(abs16(r_in.raw_dy)); w_mb = 25'(abs16(r_in.raw_dy)); end
            OP_B0: begin w_ma = {6'd0, w_mlx}; w_mb = w_mlx; end
            OP_B1: begin w_ma = {6'd0, w_mly}; w_mb = w_mly; end
            OP_B4: begin w_ma = {19'd0, w_lenc}; w_mb = {17'd0, w_k}; end
            OP_B5: begin w_ma = {11'd0, r_prod[19:0]}; w_mb = {4'd0, RECIP_TEN}; end
            OP_R0: begin w_ma = {14'd0, w_rate}; w_mb = {12'd0, w_dt}; end
            OP_S0: begin w_ma = {6'd0, w_mlx}; w_mb = {8'd0, r_frac}; end
            OP_S1: begin w_ma = {6'd0, w_mly}; w_mb = {8'd0, r_frac}; end
            OP_C1: begin w_ma = {7'd0, w_mcx}; w_mb = {9'd0, r_pgain}; end
            OP_C2: begin w_ma = {7'd0, w_mcy}; w_mb = {9'd0, r_pgain}; end
            default: w_mul = 1'b0;
        endcase
    end

    // scaled step toward current value
    logic signed [23:0] w_step_x, w_step_y;
    logic [24:0]        w_sp;
    logic signed [25:0] w_sum;
    always_comb begin
        w_sp     = r_prod[40:16];
        w_sum    = {{2{r_ox[23]}}, r_ox} + (w_lx[24] ? -{1'b0, w_sp} : {1'b0, w_sp});
        w_step_x = w_sum[23:0];
        w_sum    = {{2{r_oy[23]}}, r_oy} + (w_ly[24] ? -{1'b0, w_sp} : {1'b0, w_sp});
        w_step_y = w_sum[23:0];
    end

    // average, truncated toward zero
    logic signed [24:0] w_sx, w_sy, w_avx, w_avy;
    assign w_sx  = {r_cx[23], r_cx} + {r_ox[23], r_ox};
    assign w_sy  = {r_cy[23], r_cy} + {r_oy[23], r_oy};
    assign w_avx = (w_sx + 25'(w_sx[24] & w_sx[0])) >>> 1;
    assign w_avy = (w_sy + 25'(w_sy[24] & w_sy[0])) >>> 1;

    // mirror with saturation of the most negative value
    function automatic logic signed [23:0] mirror24(input logic signed [23:0] v);
        return (v == 24'sh800000) ? 24'sh7FFFFF : 24'(-v);
    endfunction
    logic w_mir;
    assign w_mir = r_mirror && !r_in.in_menu;

    // root step
    logic [49:0] w_trial;
    assign w_trial = r_root + r_bit;

    // cursor update and clamp
    function automatic logic [17:0] move_pos(input logic [17:0] pos,
                                             input logic neg,
                                             input logic [29:0] p,
                                             input logic [17:0] hi);
        logic signed [31:0] s;
        s = {14'd0, pos} + (neg ? -{2'd0, p} : {2'd0, p});
        if (s < 0)                  return '0;
        else if (s > {14'd0, hi})   return hi;
        else                        return s[17:0];
    endfunction
    logic [17:0] w_pos_y;
    assign w_pos_y = move_pos(r_pos_y, r_cy[23], r_prod[39:10], Y_MAX);

    // button and wheel activity
    logic [9:0] w_act;
    assign w_act = {r_in.raw_wheel[15],
                    !r_in.raw_wheel[15] && (r_in.raw_wheel != '0),
                    r_in.buttons_down & BTN_MASK};

    logic w_fire;
    assign w_fire = (i_cmd.op == OP_FIN) && o_sts.out_free;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_data;
        if (w_mul) r_prod <= 56'(w_ma * w_mb);
        case (i_cmd.op)
            OP_A2:  r_cx <= w_acc;
            OP_A4:  r_cy <= w_acc;
            OP_B1:  r_acc <= r_prod[49:0];
            OP_B2: begin
                r_rem  <= r_acc + r_prod[49:0];
                r_root <= '0;
                r_bit  <= 50'd1 << 48;
            end
            OP_SQ: begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_B6:  r_frac <= 17'(17'h10000 - {1'b0, r_prod[39:24]});
            OP_R1:  r_frac <= (r_prod[29:0] > 30'h1000000) ? 17'h10000 : r_prod[24:8];
            OP_S1:  r_cx <= w_step_x;
            OP_M0: begin
                if (w_mir) begin
                    r_cx <= mirror24(r_cx);
                    r_cy <= mirror24(r_cy);
                end
            end
            OP_AVG: begin
                r_cx <= w_avx[23:0];
                r_cy <= w_avy[23:0];
            end
            default: ;
        endcase
        if (i_cmd.op == OP_S2) r_cy <= w_step_y;
        if (w_fire) begin
            r_out.move_x        <= r_cx;
            r_out.move_y        <= r_cy;
            r_out.wheel_delta   <= r_in.raw_wheel;
            r_out.pressed_mask  <= w_act & ~r_prev_act;
            r_out.released_mask <= r_prev_act & ~w_act;
            r_out.cursor_x      <= r_pos_x;
            r_out.cursor_y      <= w_pos_y;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox        <= '0;
            r_oy        <= '0;
            r_prev_act  <= '0;
            r_pos_x     <= X_RST;
            r_pos_y     <= Y_RST;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_AVG: begin
                    r_ox <= w_avx[23:0];
                    r_oy <= w_avy[23:0];
                end
                OP_S2: begin
                    r_ox <= r_cx;
                    r_oy <= w_step_y;
                end
                OP_C2: r_pos_x <= move_pos(r_pos_x, r_cx[23], r_prod[39:10], X_MAX);
                default: ;
            endcase
            if (w_fire) begin
                r_pos_y    <= w_pos_y;
                r_prev_act <= w_act;
            end
            if (w_fire)                           r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_pos_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_x <= X_MAX)
        else $error("cursor x left the screen");
    a_pos_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_y <= Y_MAX)
        else $error("cursor y left the screen");
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.op == OP_FIN))
        else $error("result beat raised outside the final step");

endmodule

@@ rtl/pointer_motion_conditioner_unit.sv @@
// top level of the pointer motion conditioner
`timescale 1ns / 1ps
// Conditions one mouse poll per input beat: acceleration with a cap,
// one of four smoothing modes, mirroring outside menus, a clamped virtual
// cursor and press/release masks for buttons and wheel directions.
// Input channel i_in_valid / o_in_stall / i_in_data, output channel
// o_out_valid / i_out_stall / o_out_data; a beat moves when valid is high
// and stall is low. Configuration registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must write them only while no
// poll is in flight, as the block does not enforce this. One poll is worked
// at a time, so a new beat is taken no earlier than the cycle after the result
// is registered. The length of the sequence is set by the single shared
// multiplier, which every product passes through in turn, and in blend mode
// by the 25-step one-bit-per-cycle square root. A finished result sits in
// the output register while the next poll is taken; if the receiver still
// stalls when the next result is done, the sequencer waits on its last step.
// Reset restores register defaults, centers the cursor and clears the
// smoothing and button history.
module pointer_motion_conditioner_unit #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600,
    parameter int BUTTON_COUNT  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pmc_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pmc_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import pmc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    pmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    pmc_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .BUTTON_COUNT  (BUTTON_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ verif/tb_pointer_motion_conditioner_unit.sv @@
// self-checking testbench for the pointer motion conditioner unit
`timescale 1ns / 1ps
module tb_pointer_motion_conditioner_unit;
    import pmc_pkg::*;

    localparam int SCR_W = 800;
    localparam int SCR_H = 600;
    localparam int N_BTN = 8;
    localparam int SETTLE_CYCLES = 60;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pointer_motion_conditioner_unit #(
        .SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H), .BUTTON_COUNT(N_BTN)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor copy of registers and history
    longint unsigned cur_accel_gain, cur_accel_cap, cur_smooth, cur_decel, cur_mirror;
    longint unsigned cur_ptr_gain;
    longint last_smooth_x, last_smooth_y;
    longint unsigned last_active;
    longint cur_pos_x, cur_pos_y;

    t_out expected_moves[$];
    int mismatch_count;
    int hold_off_cycles;
    int sink_mode;    // 0 random stalls, 1 never stall

    function automatic longint unsigned magnitude(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    function automatic longint scale_toward_zero(longint a, longint unsigned b, int sh);
        longint unsigned p;
        p = (magnitude(a) * b) >> sh;
        return a < 0 ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint accelerate(longint d);
        longint unsigned m;
        if (cur_accel_gain == 0) return d * 256;
        m = (magnitude(d) * magnitude(d) * cur_accel_gain) >> 8;
        if (m > cur_accel_cap) m = cur_accel_cap;
        return d < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_screen(longint v, longint hi);
        if (v < 0) return 0;
        return v > hi ? hi : v;
    endfunction

    // work out one conditioned result and advance the predictor history
    function automatic t_out condition_poll(t_in p);
        t_out r;
        longint dx, dy, wh, cx, cy, ox, oy, lx, ly;
        longint unsigned len, k, w, dt, rt, amt, act;
        dx = longint'(p.raw_dx);
        dy = longint'(p.raw_dy);
        wh = longint'(p.raw_wheel);
        cx = accelerate(dx);
        cy = accelerate(dy);
        ox = last_smooth_x;
        oy = last_smooth_y;
        lx = cx - ox;
        ly = cy - oy;
        if (cur_smooth != 0) begin
            if (cur_smooth < 256) begin
                len = int_sqrt(magnitude(lx) * magnitude(lx) + magnitude(ly) * magnitude(ly));
                k = cur_smooth < 230 ? cur_smooth : 230;
                if (len > 2560) len = 2560;
                w = (len * k) / 10;
                cx = ox + scale_toward_zero(lx, 65536 - w, 16);
                cy = oy + scale_toward_zero(ly, 65536 - w, 16);
            end else if (cur_smooth == 256) begin
                cx = (cx + ox) / 2;
                cy = (cy + oy) / 2;
            end else begin
                dt = p.frame_time < 6554 ? p.frame_time : 6554;
                if (magnitude(cx) * magnitude(cx) + magnitude(cy) * magnitude(cy) < 7)
                    rt = cur_decel != 0 ? dt * cur_decel : dt * cur_smooth * 2;
                else
                    rt = dt * cur_smooth;
                if (rt > (64'd1 << 24)) rt = 64'd1 << 24;
                amt = rt >> 8;
                cx = ox + scale_toward_zero(lx, amt, 16);
                cy = oy + scale_toward_zero(ly, amt, 16);
            end
            last_smooth_x = longint'(int'(cx));
            last_smooth_y = longint'(int'(cy));
        end
        if (cur_mirror != 0 && !p.in_menu) begin
            cx = -cx;
            cy = -cy;
            if (cx > 8388607) cx = 8388607;
            if (cy > 8388607) cy = 8388607;
        end
        act = p.buttons_down & ((1 << N_BTN) - 1);
        if (wh > 0) act |= 1 << 8;
        if (wh < 0) act |= 1 << 9;
        r.pressed_mask = 10'(act & ~last_active);
        r.released_mask = 10'(last_active & ~act);
        last_active = act;
        cur_pos_x = clamp_screen(cur_pos_x + scale_toward_zero(cx, cur_ptr_gain, 10),
                                 longint'(SCR_W - 1) * 256);
        cur_pos_y = clamp_screen(cur_pos_y + scale_toward_zero(cy, cur_ptr_gain, 10),
                                 longint'(SCR_H - 1) * 256);
        r.move_x = 24'(cx);
        r.move_y = 24'(cy);
        r.wheel_delta = 16'(wh);
        r.cursor_x = 18'(cur_pos_x);
        r.cursor_y = 18'(cur_pos_y);
        return r;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // send one poll beat and record its expected result; valid stays up
    // after the beat until the next gap or drain drops it
    task automatic send_poll(t_in p, bit with_gaps);
        int gap;
        gap = with_gaps ? short_or_long_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_moves.push_back(condition_poll(p));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_moves.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only while idle; the caller drops the enable
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= CFG_DATA_W'(val);
        @(posedge i_clk);
        case (idx)
            CFG_ACCEL_GAIN:    cur_accel_gain = val & 16'hFFFF;
            CFG_ACCEL_CAP:     cur_accel_cap = val & 23'h7FFFFF;
            CFG_SMOOTH_FACTOR: cur_smooth = val & 16'hFFFF;
            CFG_DECEL_RATE:    cur_decel = val & 16'hFFFF;
            CFG_MIRROR_ENABLE: cur_mirror = val & 1;
            CFG_POINTER_GAIN:  cur_ptr_gain = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(longint unsigned ag, longint unsigned cap, longint unsigned sf,
                            longint unsigned dr, longint unsigned mir, longint unsigned pg);
        drain_results();
        write_reg(CFG_ACCEL_GAIN, ag);
        write_reg(CFG_ACCEL_CAP, cap);
        write_reg(CFG_SMOOTH_FACTOR, sf);
        write_reg(CFG_DECEL_RATE, dr);
        write_reg(CFG_MIRROR_ENABLE, mir);
        write_reg(CFG_POINTER_GAIN, pg);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in poll_of(int dx, int dy, int wh, int btn, int ft, bit menu);
        t_in p;
        p.raw_dx = 16'(dx);
        p.raw_dy = 16'(dy);
        p.raw_wheel = 16'(wh);
        p.buttons_down = 8'(btn);
        p.frame_time = 16'(ft);
        p.in_menu = menu;
        return p;
    endfunction

    function automatic t_in random_poll();
        t_in p;
        p = t_in'(73'({$urandom(), $urandom(), $urandom()}));
        case ($urandom_range(0, 3))
            0: begin
                p.raw_dx = 16'($signed($urandom_range(0, 64)) - 32);
                p.raw_dy = 16'($signed($urandom_range(0, 64)) - 32);
            end
            1: begin
                p.raw_dx = 16'($signed($urandom_range(0, 6)) - 3);
                p.raw_dy = 16'($signed($urandom_range(0, 6)) - 3);
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) p.raw_wheel = 16'd0;
        return p;
    endfunction

    // directed extremes and special cases
    task automatic test_directed();
        send_poll(poll_of(0, 0, 0, 0, 0, 0), 0);
        send_poll(poll_of(32767, -32768, 32767, 8'hFF, 65535, 1), 0);
        send_poll(poll_of(-32768, 32767, -32768, 8'h00, 0, 0), 0);
        send_poll(poll_of(-32768, -32768, 1, 8'hA5, 100, 0), 0);
        send_poll(poll_of(32767, 32767, -1, 8'h5A, 100, 0), 0);
        send_poll(poll_of(0, 0, 0, 8'h00, 0, 0), 0);
        // acceleration with zero cap
        set_regs(65535, 0, 0, 0, 0, 819);
        send_poll(poll_of(100, -100, 0, 1, 0, 0), 0);
        // acceleration with max cap and mirroring of large negative values
        set_regs(65535, 8388607, 0, 0, 1, 65535);
        send_poll(poll_of(-32768, -32768, 0, 2, 0, 0), 0);
        send_poll(poll_of(32767, 5, 0, 2, 0, 1), 0);
        send_poll(poll_of(-3, 7, 0, 0, 0, 0), 0);
        // each smoothing mode
        set_regs(0, 25600, 1, 0, 0, 819);
        send_poll(poll_of(50, -20, 3, 3, 0, 0), 0);
        send_poll(poll_of(-32768, 32767, 0, 0, 0, 0), 0);
        set_regs(0, 25600, 255, 0, 0, 819);
        send_poll(poll_of(10, 10, 0, 0, 0, 0), 0);
        set_regs(0, 25600, 256, 0, 0, 819);
        send_poll(poll_of(-7, 9, 0, 0, 0, 0), 0);
        send_poll(poll_of(-7, 9, 0, 0, 0, 0), 0);
        set_regs(0, 25600, 65535, 0, 0, 819);
        send_poll(poll_of(200, -200, 0, 0, 65535, 0), 0);
        send_poll(poll_of(0, 0, 0, 0, 3000, 0), 0);
        set_regs(0, 25600, 257, 65535, 0, 819);
        send_poll(poll_of(0, 0, 0, 0, 6554, 0), 0);
        send_poll(poll_of(1, 0, 0, 0, 6553, 0), 0);
    endtask

    // random polls over a set of register settings
    task automatic test_random_settings();
        int phase, n;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_regs(0, 25600, 0, 0, 0, 819);
                1: set_regs($urandom_range(1, 65535), $urandom_range(0, 8388607),
                            $urandom_range(1, 255), 0, 1, $urandom_range(0, 65535));
                2: set_regs($urandom_range(1, 300), 25600, 256, 0, 0, 4096);
                3: set_regs(0, 25600, $urandom_range(257, 65535),
                            $urandom_range(0, 65535), 1, 819);
                4: set_regs(0, 25600, $urandom_range(257, 2000), 0, 0, 65535);
                5: set_regs(65535, 8388607, 230, 0, 1, 0);
                6: set_regs($urandom_range(0, 65535), $urandom_range(0, 8388607),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 1), $urandom_range(0, 65535));
                default: set_regs(0, 25600, $urandom_range(1, 229), 0, 0, 819);
            endcase
            for (n = 0; n < 55; n++) send_poll(random_poll(), phase != 0);
        end
    endtask

    // receiver holds off long while polls keep coming, then sender waits for drain; then a never-stalling receiver
    task automatic test_backpressure();
        int n;
        drain_results();
        hold_off_cycles = 300;
        for (n = 0; n < 6; n++) send_poll(random_poll(), 0);
        drain_results();
        sink_mode = 1;
        for (n = 0; n < 40; n++) send_poll(random_poll(), 0);
        sink_mode = 0;
        drain_results();
    endtask

    // receiver stall generation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (sink_mode == 1) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 3) == 0)
                || ($urandom_range(0, 60) == 0 && o_out_valid);
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_out exp_move;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_moves.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %p", o_out_data);
            end else begin
                exp_move = expected_moves.pop_front();
                if (o_out_data !== exp_move) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", exp_move, o_out_data);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ACCEL_GAIN;
        i_cfg_wdata = '0;
        mismatch_count = 0;
        hold_off_cycles = 0;
        sink_mode = 0;
        cur_accel_gain = 0;
        cur_accel_cap = 25600;
        cur_smooth = 0;
        cur_decel = 0;
        cur_mirror = 0;
        cur_ptr_gain = 819;
        last_smooth_x = 0;
        last_smooth_y = 0;
        last_active = 0;
        cur_pos_x = 102400;
        cur_pos_y = 76800;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_settings();
        test_backpressure();
        if (mismatch_count == 0 && expected_moves.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

@@ files.f @@
rtl/pmc_pkg.sv
rtl/pmc_ctrl.sv
rtl/pmc_dp.sv
rtl/pointer_motion_conditioner_unit.sv
verif/tb_pointer_motion_conditioner_unit.sv
